// ===== design/tickless_os_tick_unit_assert.svh =====
// Assertion macros used by the checker file of the tick unit.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef TICKLESS_OS_TICK_UNIT_ASSERT_SVH
`define TICKLESS_OS_TICK_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tou_pkg.sv =====
// Shared types and constants for the tickless OS tick unit.
// No dependencies; used by the top level, the serial divider, the checker and the testbench.
package tou_pkg;

  localparam int COUNTER_BITS_DEF = 24;
  localparam int PERIOD_W         = 16;
  localparam int OUT_W            = 24;
  localparam int IDLE_W           = 32;
  localparam int CNT_IN_W         = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

// ===== design/tou_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on tou_pkg for the divisor width.
module tou_divider import tou_pkg::*; #(
  parameter int DVD_W = COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                done,
  output logic [DVD_W-1:0]    quotient,
  output logic [PERIOD_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DVD_W-1:0]    dvd;
  logic [PERIOD_W-1:0] dvs;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   rem_sub;
  logic                q_bit;
  logic [PERIOD_W-1:0] rem_next;

  // The dividend register doubles as the quotient: bits leave at the top
  // and quotient bits enter at the bottom.
  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs};
  assign q_bit     = (rem_shift >= {1'b0, dvs});
  assign rem_next  = q_bit ? rem_sub[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

// ===== design/tickless_os_tick_unit.sv =====
// Tickless OS tick accountant over a wrapping COUNTER_BITS-wide counter. A tick event
// (cmd 0) divides the signed counter distance since the last whole OS tick by the
// period, reports the elapsed ticks and issues the compare value of the next tick; an
// idle request (cmd 1) clamps the sleep length to 2^(COUNTER_BITS-2) counter ticks and
// issues its compare value, or nothing for zero ticks. An accepted word passes through
// the serial divider, one quotient bit per cycle, then the divider's done flag, the
// offset step and the output register before its result word appears. in_stall is high
// for that time, so no new word is taken before the last one is through. One result
// waiting on out_stall does not block acceptance of the next word; a second finished
// word waits, with in_stall high, until the first is taken. Write ticks_per_os_tick
// only while the block is idle; a value of zero acts as one.
module tickless_os_tick_unit import tou_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ticks_per_os_tick_we,
  input  logic [PERIOD_W-1:0]  ticks_per_os_tick,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [CNT_IN_W-1:0]  counter_now,
  input  logic [IDLE_W-1:0]    idle_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [OUT_W-1:0] elapsed_ticks,
  output logic                 compare_write,
  output logic [OUT_W-1:0]     compare_value
);

  localparam int CB = COUNTER_BITS;
  localparam logic [CB-1:0] IDLE_SPAN = CB'(1) << (CB - 2);

  state_t state;

  logic [PERIOD_W-1:0] period_cfg;
  logic [PERIOD_W-1:0] period;
  logic [CB-1:0]       last_tick_count;

  logic                cmd_r;
  logic                sign_r;
  logic                zero_r;
  logic [CB-1:0]       now_r;
  logic [IDLE_W-1:0]   idle_r;
  logic [CB-1:0]       off_r;

  logic                accept;
  logic [CB-1:0]       now_cb;
  logic [CB-1:0]       diff;
  logic [CB-1:0]       abs_diff;
  logic [CB-1:0]       dividend;

  logic                div_done;
  logic [CB-1:0]       quot;
  logic [PERIOD_W-1:0] rem;
  logic [CB-1:0]       rem_cb;
  logic [CB+PERIOD_W-1:0] prod;
  logic [CB-1:0]       off_next;

  logic                out_free;
  logic [CB-1:0]       base;
  logic [CB-1:0]       sum;
  logic [CB-1:0]       cmp_cb;
  logic signed [CB-1:0] ticks_s;

  assign period   = (period_cfg == '0) ? PERIOD_W'(1) : period_cfg;
  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  assign now_cb   = CB'(counter_now);
  assign diff     = now_cb - last_tick_count;
  assign abs_diff = diff[CB-1] ? (CB'(0) - diff) : diff;
  assign dividend = (cmd == CMD_IDLE) ? IDLE_SPAN : abs_diff;

  tou_divider #(
    .DVD_W (CB)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (dividend),
    .divisor   (period),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // Tick event: the new tick base is now minus the signed remainder.
  // Idle request: a clamped sleep spans the largest multiple of the period
  // that fits, otherwise exactly idle_ticks periods.
  assign rem_cb = CB'(rem);
  assign prod   = {{PERIOD_W{1'b0}}, CB'(idle_r)} * {{CB{1'b0}}, period};

  always_comb begin
    if (cmd_r == CMD_TICK) begin
      off_next = sign_r ? rem_cb : (CB'(0) - rem_cb);
    end else if (idle_r > IDLE_W'(quot)) begin
      off_next = IDLE_SPAN - rem_cb;
    end else begin
      off_next = prod[CB-1:0];
    end
  end

  assign base    = (cmd_r == CMD_TICK) ? now_r : last_tick_count;
  assign sum     = base + off_r;
  assign cmp_cb  = (cmd_r == CMD_TICK) ? (sum + CB'(period)) : sum;
  assign ticks_s = sign_r ? signed'(CB'(0) - quot) : signed'(quot);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      period_cfg      <= PERIOD_RESET;
      last_tick_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (ticks_per_os_tick_we) begin
        period_cfg <= ticks_per_os_tick;
      end
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (cmd_r == CMD_TICK) begin
              last_tick_count <= sum;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      sign_r <= diff[CB-1];
      zero_r <= (idle_ticks == '0);
      now_r  <= now_cb;
      idle_r <= idle_ticks;
    end
    if (state == S_MUL) begin
      off_r <= off_next;
    end
    if ((state == S_FIN) && out_free) begin
      if (cmd_r == CMD_TICK) begin
        elapsed_ticks <= OUT_W'(ticks_s);
        compare_write <= 1'b1;
        compare_value <= OUT_W'(cmp_cb);
      end else begin
        elapsed_ticks <= '0;
        compare_write <= !zero_r;
        compare_value <= zero_r ? '0 : OUT_W'(cmp_cb);
      end
    end
  end

endmodule

// ===== design/tou_checker.sv =====
// Port-level checks for the tickless OS tick unit, bound to the top level.
// Depends on tou_pkg and the macros in tickless_os_tick_unit_assert.svh.
`include "tickless_os_tick_unit_assert.svh"

module tou_checker import tou_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    ticks_per_os_tick_we,
  input logic [PERIOD_W-1:0]     ticks_per_os_tick,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    cmd,
  input logic [CNT_IN_W-1:0]     counter_now,
  input logic [IDLE_W-1:0]       idle_ticks,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] elapsed_ticks,
  input logic                    compare_write,
  input logic [OUT_W-1:0]        compare_value
);

  // A stalled result word stays put.
  `TOU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(compare_value) && $stable(elapsed_ticks) && $stable(compare_write), "stalled result word changed")

  // Without a compare write the compare value reads as zero.
  `TOU_ASSERT_SAME(a_cmp_zero, out_valid && !compare_write, compare_value == '0, "compare value set without a compare write")

  // Every tick event writes a compare, so a word without one is an idle word.
  `TOU_ASSERT_SAME(a_idle_zero, out_valid && !compare_write, elapsed_ticks == '0, "elapsed ticks nonzero on a word without a compare write")

  // The block is busy in the cycle after it takes a word.
  `TOU_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "input taken again right after a word was accepted")

endmodule

bind tickless_os_tick_unit tou_checker u_tou_checker (.*);

// ===== sim/tickless_os_tick_unit_test.sv =====
// Self-checking testbench for the tickless OS tick unit: directed and random words
// under several flow-control patterns, checked against a behavioral predictor.
// Depends on tou_pkg and the tickless_os_tick_unit RTL.
`timescale 1ns / 100ps

module tickless_os_tick_unit_test;
  import tou_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS = 190;

  typedef struct packed {
    logic [OUT_W-1:0] elapsed;
    logic             wr;
    logic [OUT_W-1:0] cmp;
  } tick_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                ticks_per_os_tick_we = 1'b0;
  logic [PERIOD_W-1:0] ticks_per_os_tick = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_TICK;
  logic [CNT_IN_W-1:0] counter_now = '0;
  logic [IDLE_W-1:0]   idle_ticks = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [OUT_W-1:0] elapsed_ticks;
  logic                compare_write;
  logic [OUT_W-1:0]    compare_value;

  // Predictor state: the stored tick boundary and the programmed period.
  logic [23:0]         model_last = '0;
  logic [PERIOD_W-1:0] model_period = PERIOD_RESET;

  tick_result_t expected_results[$];
  int error_count = 0;
  int results_checked = 0;
  int words_sent = 0;
  int periods_written = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  tickless_os_tick_unit dut (
    .clk(clk),
    .rst(rst),
    .ticks_per_os_tick_we(ticks_per_os_tick_we),
    .ticks_per_os_tick(ticks_per_os_tick),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .counter_now(counter_now),
    .idle_ticks(idle_ticks),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .elapsed_ticks(elapsed_ticks),
    .compare_write(compare_write),
    .compare_value(compare_value)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int eff_period();
    return (model_period == 0) ? 1 : int'(model_period);
  endfunction

  // Works out the result of one accepted word and, for a tick event, advances the tick boundary.
  function automatic tick_result_t account_word(logic c, logic [23:0] cn, logic [31:0] it);
    tick_result_t r;
    logic [23:0] diff;
    int p;
    int delta;
    int quot;
    longint unsigned t;
    longint unsigned max_sleep;
    r = '0;
    p = eff_period();
    if (c == CMD_TICK) begin
      diff = cn - model_last;
      delta = $signed(diff);
      quot = delta / p;
      model_last = model_last + quot * p;
      r.elapsed = quot[23:0];
      r.wr = 1'b1;
      r.cmp = model_last + p;
    end else if (it != 0) begin
      max_sleep = (64'd1 << 22) / longint'(p);
      t = it;
      if (t > max_sleep) t = max_sleep;
      r.wr = 1'b1;
      r.cmp = 24'(longint'(model_last) + t * longint'(p));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch at result %0d: %s got %h, expected %h", results_checked, what,
               got, want);
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", {8'h0, compare_value}, '0);
      end else begin
        want = expected_results.pop_front();
        if (elapsed_ticks !== want.elapsed)
          report_mismatch("elapsed_ticks", {8'h0, elapsed_ticks}, {8'h0, want.elapsed});
        if (compare_write !== want.wr)
          report_mismatch("compare_write", {31'h0, compare_write}, {31'h0, want.wr});
        if (compare_value !== want.cmp)
          report_mismatch("compare_value", {8'h0, compare_value}, {8'h0, want.cmp});
      end
      results_checked++;
    end
  end

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_word(logic c, logic [23:0] cn, logic [31:0] it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      cmd = $urandom;
      counter_now = $urandom;
      idle_ticks = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    counter_now = cn;
    idle_ticks = it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(account_word(c, cn, it));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    wait_drained();
    ticks_per_os_tick_we = 1'b1;
    ticks_per_os_tick = value;
    @(negedge clk);
    ticks_per_os_tick_we = 1'b0;
    ticks_per_os_tick = $urandom;
    model_period = value;
    periods_written++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 67; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 67; end
      default: begin send_gap_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  // Mostly counters a few periods around the stored boundary, so that the
  // division and the boundary update see realistic distances.
  function automatic logic [23:0] pick_counter();
    int p;
    p = eff_period();
    case ($urandom_range(9))
      0, 1, 2, 3: return model_last + $urandom_range(0, 4 * p);
      4: return model_last + $urandom_range(0, 8) * p;
      5: return model_last - $urandom_range(0, 4 * p);
      6: return model_last + 24'h7FFFFF - $urandom_range(0, 3);
      7: return model_last + 24'h800000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_idle();
    int max_sleep;
    max_sleep = (1 << 22) / eff_period();
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3: return $urandom_range(1, 8);
      4, 5: return $urandom_range((max_sleep > 2) ? max_sleep - 2 : 1, max_sleep + 2);
      6: return $urandom_range(1, max_sleep);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_tick_events_at_reset();
    send_word(CMD_TICK, 24'h000000, '0);
    send_word(CMD_TICK, 24'hFFFFFF, '0);
    send_word(CMD_TICK, 24'h7FFFFF, '0);
    send_word(CMD_TICK, model_last + 24'h800000, '0);
    send_word(CMD_TICK, model_last + 24'h000100, '0);
  endtask

  task automatic test_idle_requests_at_reset();
    send_word(CMD_IDLE, 24'hFFFFFF, 32'h0000_0000);
    send_word(CMD_IDLE, 24'h000000, 32'h0000_0001);
    send_word(CMD_IDLE, 24'h000000, 32'd16384);
    send_word(CMD_IDLE, 24'h000000, 32'd16385);
    send_word(CMD_IDLE, 24'h000000, 32'hFFFF_FFFF);
  endtask

  // Smallest, zero, 2^15 and largest (all ones) periods.
  task automatic test_period_extremes();
    write_period(16'd1);
    send_word(CMD_TICK, model_last + 24'h7FFFFF, '0);
    send_word(CMD_TICK, model_last + 24'h800000, '0);
    send_word(CMD_IDLE, 24'h0, 32'hFFFF_FFFF);
    write_period(16'd0);
    send_word(CMD_TICK, model_last + 24'd5, '0);
    send_word(CMD_IDLE, 24'h0, 32'd3);
    write_period(16'd32768);
    send_word(CMD_TICK, model_last - 24'd40000, '0);
    send_word(CMD_IDLE, 24'h0, 32'd129);
    write_period(16'hFFFF);
    send_word(CMD_TICK, model_last + 24'd200000, '0);
    send_word(CMD_TICK, model_last - 24'd65534, '0);
    send_word(CMD_IDLE, 24'h0, 32'd65);
  endtask

  task automatic test_random_traffic();
    logic [PERIOD_W-1:0] period_val;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: period_val = 16'd1;
        1: period_val = 16'd32768;
        2: period_val = 16'd0;
        3: period_val = 16'hFFFF;
        4: period_val = 16'd7;
        5: period_val = 16'd256;
        default: period_val = $urandom;
      endcase
      write_period(period_val);
      set_idling(ph % 4);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(9) < 7)
          send_word(CMD_TICK, pick_counter(), $urandom);
        else
          send_word(CMD_IDLE, $urandom, pick_idle());
      end
    end
    set_idling(0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_tick_events_at_reset();
    test_idle_requests_at_reset();
    test_period_extremes();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sent %0d words (tick events and idle requests) over %0d period settings,",
             words_sent, periods_written);
    $display("checked %0d results with mixed source gaps and sink stalls, %0d errors",
             results_checked, error_count);
    if (error_count == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
